FILE: hdl/deq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_LIST_RD = 2'd1,
    ST_LIST_WR = 2'd2
  } state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic list_go;
    logic idx_last;
  } dp_stat_t;

endpackage

FILE: hdl/deq_if.sv
// Valid/ready channel interfaces for queue requests and results.
interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::OP_W-1:0]             operation;
  logic signed [deq_pkg::DATA_W-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::DATA_W-1:0]    element;
  logic [deq_pkg::STATUS_W-1:0]         status;
  logic                                 last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

FILE: hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_W,
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/deq_ctrl.sv
// Controller state machine: request acceptance and list sequencing.
module deq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  deq_pkg::dp_stat_t   st,
  output deq_pkg::ctrl_cmd_t  cmd
);

  deq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (in_valid && st.out_free && st.list_go) state_nxt = deq_pkg::ST_LIST_RD;
      end
      deq_pkg::ST_LIST_RD: begin
        state_nxt = deq_pkg::ST_LIST_WR;
      end
      deq_pkg::ST_LIST_WR: begin
        if (st.out_free) begin
          state_nxt = st.idx_last ? deq_pkg::ST_IDLE : deq_pkg::ST_LIST_RD;
        end
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        in_ready = st.out_free;
        cmd.take = in_valid && st.out_free;
      end
      deq_pkg::ST_LIST_RD: begin
        cmd.rd = 1'b1;
      end
      deq_pkg::ST_LIST_WR: begin
        cmd.emit = st.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/deq_dp.sv
// Datapath: ring pointers, entry RAM and result register.
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [deq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [deq_pkg::DATA_W-1:0] out_element,
  output logic [deq_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_last,
  input  deq_pkg::ctrl_cmd_t                cmd,
  output deq_pkg::dp_stat_t                 st
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_CNT = OW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [deq_pkg::DATA_W-1:0] elem_r;
  logic [deq_pkg::STATUS_W-1:0]      status_r;
  logic                              last_r;

  logic          full, empty;
  logic [AW:0]   back_sum, rd_sum, inc_sum;
  logic [AW-1:0] back_pos, rd_pos, inc_pos;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [deq_pkg::DATA_W-1:0] ram_rdata;
  logic          load;
  logic signed [deq_pkg::DATA_W-1:0] ld_elem;
  deq_pkg::status_t                  ld_status;
  logic                              ld_last;

  assign full  = (occ_r == FULL_CNT);
  assign empty = (occ_r == '0);

  // front + offset, folded back into the ring
  assign back_sum = {1'b0, front_r} + (AW+1)'(occ_r);
  assign back_pos = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
  assign rd_sum   = {1'b0, front_r} + (AW+1)'(idx_r);
  assign rd_pos   = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);
  assign inc_sum  = {1'b0, front_r} + (AW+1)'(1);
  assign inc_pos  = (inc_sum >= DEPTH_W) ? AW'(inc_sum - DEPTH_W) : AW'(inc_sum);

  assign st.out_free = !out_valid_r || out_ready;
  assign st.list_go  = (in_operation == deq_pkg::OP_LIST) && !empty;
  assign st.idx_last = (OW'(idx_r + OW'(1)) == occ_r);

  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_waddr = back_pos;
    load      = 1'b0;
    ld_elem   = '0;
    ld_status = deq_pkg::STAT_OK;
    ld_last   = 1'b1;
    if (cmd.take) begin
      unique case (deq_pkg::op_t'(in_operation))
        deq_pkg::OP_PUSH_FRONT: begin
          load = 1'b1;
          if (full) begin
            ld_status = deq_pkg::STAT_OVER;
          end else begin
            front_nxt = (front_r == '0) ? LAST_POS : AW'(front_r - AW'(1));
            ram_we    = 1'b1;
            ram_waddr = front_nxt;
            occ_nxt   = OW'(occ_r + OW'(1));
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          load = 1'b1;
          if (full) begin
            ld_status = deq_pkg::STAT_OVER;
          end else begin
            ram_we  = 1'b1;
            occ_nxt = OW'(occ_r + OW'(1));
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          load = 1'b1;
          if (empty) begin
            ld_status = deq_pkg::STAT_UNDER;
          end else begin
            front_nxt = inc_pos;
            occ_nxt   = OW'(occ_r - OW'(1));
          end
        end
        deq_pkg::OP_POP_BACK: begin
          load = 1'b1;
          if (empty) begin
            ld_status = deq_pkg::STAT_UNDER;
          end else begin
            occ_nxt = OW'(occ_r - OW'(1));
          end
        end
        deq_pkg::OP_LIST: begin
          idx_nxt = '0;
          if (empty) begin
            load      = 1'b1;
            ld_status = deq_pkg::STAT_EMPTY;
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit) begin
      load    = 1'b1;
      ld_elem = ram_rdata;
      ld_last = st.idx_last;
      idx_nxt = OW'(idx_r + OW'(1));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      elem_r   <= ld_elem;
      status_r <= ld_status;
      last_r   <= ld_last;
    end
  end

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (cmd.rd),
    .raddr (rd_pos),
    .rdata (ram_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_element = elem_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT) else $error("occupancy above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, front_r} < DEPTH_W) else $error("front pointer outside ring");

  a_list_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (idx_r < occ_r)) else $error("list read past last entry");

  a_list_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> $stable(occ_r) && $stable(front_r))
    else $error("queue changed during list");

endmodule

FILE: hdl/double_ended_queue.sv
// Top level of the double-ended queue: controller, datapath and channel wiring.
//
//  channel | dir | fields                      | handshake
//  --------+-----+-----------------------------+----------------------
//  in_if   | in  | operation[2:0], value[31:0] | valid/ready
//  out_if  | out | element[31:0], status[1:0], | valid/ready
//          |     | last                        |
//
// Insert, remove and unused codes complete on acceptance; a new item is taken every
// cycle while no list is running and the result register is free or being drained.
// List steps through each stored element with a RAM read state, then a result load state.
// Reset (rst_n low, synchronous) empties the queue; entry contents are kept.
// A stalled result holds the input side off; the result register parts both sides.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_if,
  deq_out_if.source out_if
);

  deq_pkg::ctrl_cmd_t cmd;
  deq_pkg::dp_stat_t  st;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_if.operation),
    .in_value     (in_if.value),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_element  (out_if.element),
    .out_status   (out_if.status),
    .out_last     (out_if.last),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for double_ended_queue: random and directed items, mirror-model check.
`timescale 1ns / 100ps

module testbench;

  localparam int QDEPTH       = deq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 2 * QDEPTH + 10;
  localparam int STALL_LIMIT  = 3000;

  localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [deq_pkg::DATA_W-1:0] element;
    deq_pkg::status_t                  status;
    logic                              last;
  } deq_result_t;

  class deque_mirror;
    logic [deq_pkg::DATA_W-1:0] slots [QDEPTH];
    int                         head;
    int                         count;
    int                         errors;
    deq_result_t                expected [$];

    function int pending();
      return expected.size();
    endfunction

    function void add_result(logic [deq_pkg::DATA_W-1:0] element, deq_pkg::status_t status,
                             logic last);
      deq_result_t r;
      r.element = element;
      r.status  = status;
      r.last    = last;
      expected.push_back(r);
    endfunction

    function void apply_request(logic [deq_pkg::OP_W-1:0] op,
                                logic [deq_pkg::DATA_W-1:0] word);
      case (op) inside
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          if (count == QDEPTH) begin
            add_result('0, deq_pkg::STAT_OVER, 1'b1);
          end else begin
            if (op == deq_pkg::OP_PUSH_FRONT) begin
              head = (head + QDEPTH - 1) % QDEPTH;
              slots[head] = word;
            end else begin
              slots[(head + count) % QDEPTH] = word;
            end
            count++;
            add_result('0, deq_pkg::STAT_OK, 1'b1);
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          if (count == 0) begin
            add_result('0, deq_pkg::STAT_UNDER, 1'b1);
          end else begin
            if (op == deq_pkg::OP_POP_FRONT) head = (head + 1) % QDEPTH;
            count--;
            add_result('0, deq_pkg::STAT_OK, 1'b1);
          end
        end
        deq_pkg::OP_LIST: begin
          if (count == 0) begin
            add_result('0, deq_pkg::STAT_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < count; i++)
              add_result(slots[(head + i) % QDEPTH], deq_pkg::STAT_OK, i == count - 1);
          end
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic signed [deq_pkg::DATA_W-1:0] element,
                      logic [deq_pkg::STATUS_W-1:0] status, logic last);
      deq_result_t want;
      if (expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result element %0d status %0d last %0b",
                                element, status, last));
        return;
      end
      want = expected.pop_front();
      if (element !== want.element)
        flag_mismatch($sformatf("element %0d, expected %0d", element, want.element));
      if (status !== want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic src_quiet;
  logic sink_quiet;
  logic stall_req;
  int   quiet_cycles;

  deque_mirror mirror = new();

  deq_in_if  in_if ();
  deq_out_if out_if ();

  double_ended_queue #(.DEPTH(QDEPTH)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) mirror.apply_request(in_if.operation, in_if.value);
      if (out_if.valid && out_if.ready)
        mirror.check_result(out_if.element, out_if.status, out_if.last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("double_ended_queue verification failed");
        $finish;
      end
    end
  end

  // result sink: random back-pressure, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_if.ready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 28);
    end
  end

  task automatic send_item(logic [deq_pkg::OP_W-1:0] op, logic [deq_pkg::DATA_W-1:0] word);
    while (!src_quiet && $urandom_range(99) < 28) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= word;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [deq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int                        counted;
    int                        mode;
    int                        roll;
    logic [deq_pkg::OP_W-1:0]  op;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = deq_pkg::OP_PUSH_FRONT;
    in_if.value     = '0;
    src_quiet       = 1'b0;
    sink_quiet      = 1'b0;
    stall_req       = 1'b0;
    counted         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty-queue cases, extremes, front wrap, spare codes
    send_item(deq_pkg::OP_LIST, '0);
    send_item(deq_pkg::OP_POP_FRONT, '0);
    send_item(deq_pkg::OP_POP_BACK, '0);
    send_item(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
    send_item(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_item(deq_pkg::OP_PUSH_FRONT, '0);
    send_item(deq_pkg::OP_PUSH_BACK, '1);
    send_item(deq_pkg::OP_LIST, 32'h1234_5678);
    send_item(OP_SPARE_A, 32'h5555_5555);
    send_item(OP_SPARE_B, 32'haaaa_aaaa);
    send_item(OP_SPARE_C, '1);
    send_item(deq_pkg::OP_POP_FRONT, '1);
    send_item(deq_pkg::OP_POP_BACK, '1);
    send_item(deq_pkg::OP_LIST, '0);
    send_item(deq_pkg::OP_POP_BACK, '0);
    send_item(deq_pkg::OP_POP_FRONT, '0);
    send_item(deq_pkg::OP_POP_FRONT, '0);
    send_item(deq_pkg::OP_LIST, '0);
    wait_drained();

    // fill to full behind a stalled sink, then overflow both ends and list all
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    stall_req  = 1'b1;
    repeat (QDEPTH + 2) send_item(deq_pkg::OP_PUSH_BACK, pick_word());
    send_item(deq_pkg::OP_PUSH_FRONT, pick_word());
    send_item(deq_pkg::OP_LIST, '0);
    wait_drained();
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;

    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(2);
      repeat (30) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          case ($urandom_range(2))
            0:       op = OP_SPARE_A;
            1:       op = OP_SPARE_B;
            default: op = OP_SPARE_C;
          endcase
        end else begin
          counted++;
          roll = $urandom_range(99);
          if (roll < 8)
            op = deq_pkg::OP_LIST;
          else if (roll < (mode == 0 ? 78 : (mode == 1 ? 38 : 55)))
            op = $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
          else
            op = $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
        end
        send_item(op, pick_word());
      end
      if ($urandom_range(3) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/deq_pkg.sv
hdl/deq_if.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue.sv
test/testbench.sv
